>>> design/hufd_pkg.sv
// Shared types and constants of the Huffman tree bit decoder.
package hufd_pkg;

  localparam int NODE_COUNT = 512;
  localparam int ADDR_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int IDX_W      = 9;
  localparam int SYM_W      = 8;
  localparam int DATA_W     = 8;
  localparam int OP_W       = 2;
  localparam int REM_W      = $clog2(DATA_W + 1);

  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_DECODE  = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_or_symbol;
  } node_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    node_entry_t      entry;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } tbl_rd_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FETCH  = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

>>> design/hufd_in_if.sv
// Request channel of the decoder: op code, coded byte and node entry fields.
interface hufd_in_if;
  logic                       valid;
  logic                       ready;
  logic [hufd_pkg::OP_W-1:0]  op;
  logic [hufd_pkg::DATA_W-1:0] data_byte;
  logic [hufd_pkg::IDX_W-1:0] node_index;
  logic                       node_is_leaf;
  logic [hufd_pkg::IDX_W-1:0] left_child;
  logic [hufd_pkg::IDX_W-1:0] right_or_symbol;

  modport source (output valid, op, data_byte, node_index, node_is_leaf, left_child,
                  right_or_symbol, input ready);
  modport sink (input valid, op, data_byte, node_index, node_is_leaf, left_child,
                right_or_symbol, output ready);
endinterface

>>> design/hufd_out_if.sv
// Result channel of the decoder: one decoded symbol per transfer, with its last_of_byte flag.
interface hufd_out_if;
  logic                       valid;
  logic                       ready;
  logic [hufd_pkg::SYM_W-1:0] symbol;
  logic                       last_of_byte;

  modport source (output valid, symbol, last_of_byte, input ready);
  modport sink (input valid, symbol, last_of_byte, output ready);
endinterface

>>> design/hufd_node_table.sv
// Node table memory with one write port and one registered read port.
module hufd_node_table (
  input  logic                  clk,
  input  hufd_pkg::tbl_wr_t     wr,
  input  hufd_pkg::tbl_rd_t     rd,
  output hufd_pkg::node_entry_t rd_entry
);
  import hufd_pkg::*;

  node_entry_t mem [NODE_COUNT];
  node_entry_t q_r;
  logic        oor_r;

  always_ff @(posedge clk) begin
    if (wr.en && (int'(wr.idx) < NODE_COUNT)) begin
      mem[ADDR_W'(wr.idx)] <= wr.entry;
    end
  end

  // An index beyond the table reads as an inner node whose children are node 0.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      q_r   <= mem[ADDR_W'(rd.idx)];
      oor_r <= !(int'(rd.idx) < NODE_COUNT);
    end
  end

  assign rd_entry = oor_r ? '0 : q_r;

endmodule

>>> design/huffman_tree_bit_decoder_core.sv
// Huffman tree bit decoder: walks a code tree in the node table one coded bit at a
// time, most significant bit first, and emits one symbol for every leaf reached.
// A node write, a restart or an unused op is done in the idle state. A data byte is
// taken in, the walk's current node is fetched, and the walk then steps once per
// bit; each symbol that ends before the last bit adds a step in which the leaf is
// seen and a fetch of the root again, and the byte closes through the finish state.
// A root that is itself a leaf is seen and fetched again for every bit. The result
// side can hold the walk back, and a new request is taken only in the idle state.
// The node table has a single registered read port: one node read per cycle. The
// last symbol of a byte is held back until the byte ends, so that it can carry the
// last_of_byte flag.
module huffman_tree_bit_decoder_core (
  input  logic                       clk,
  input  logic                       rst_n,
  hufd_in_if.sink                    in_req,
  hufd_out_if.source                 out_res,
  input  logic                       cfg_we,
  input  logic [hufd_pkg::IDX_W-1:0] cfg_wdata
);
  import hufd_pkg::*;

  state_t               state_r, state_nxt;
  logic [DATA_W-1:0]    data_r, data_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  logic                 started_r, started_nxt;
  logic                 from_child_r, from_child_nxt;
  logic [IDX_W-1:0]     root_r;
  logic                 hold_valid_r, hold_valid_nxt;
  logic [SYM_W-1:0]     hold_sym_r, hold_sym_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]     out_sym_r, out_sym_nxt;
  logic                 out_last_r, out_last_nxt;

  tbl_wr_t              tbl_wr;
  tbl_rd_t              tbl_rd;
  node_entry_t          entry;

  logic                 accept;
  logic                 out_free;
  logic                 emit;
  logic                 stall;
  logic [IDX_W-1:0]     child;
  logic [REM_W-1:0]     rem_after;

  hufd_node_table u_table (
    .clk      (clk),
    .wr       (tbl_wr),
    .rd       (tbl_rd),
    .rd_entry (entry)
  );

  assign in_req.ready     = (state_r == ST_IDLE);
  assign accept           = in_req.valid && in_req.ready;
  assign out_free         = !out_valid_r || out_res.ready;
  assign emit             = (state_r == ST_WALK) && entry.leaf;
  assign stall            = emit && hold_valid_r && !out_free;
  assign child            = data_r[DATA_W-1] ? entry.right_or_symbol : entry.left_child;
  assign rem_after        = from_child_r ? rem_r : rem_r - REM_W'(1);

  assign tbl_wr.en              = accept && (in_req.op == OP_WRITE);
  assign tbl_wr.idx             = in_req.node_index;
  assign tbl_wr.entry.leaf      = in_req.node_is_leaf;
  assign tbl_wr.entry.left_child      = in_req.left_child;
  assign tbl_wr.entry.right_or_symbol = in_req.right_or_symbol;

  assign out_res.valid        = out_valid_r;
  assign out_res.symbol       = out_sym_r;
  assign out_res.last_of_byte = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    data_nxt       = data_r;
    rem_nxt        = rem_r;
    pos_nxt        = pos_r;
    started_nxt    = started_r;
    from_child_nxt = from_child_r;
    hold_valid_nxt = hold_valid_r;
    hold_sym_nxt   = hold_sym_r;
    out_valid_nxt  = out_res.ready ? 1'b0 : out_valid_r;
    out_sym_nxt    = out_sym_r;
    out_last_nxt   = out_last_r;
    tbl_rd.en      = 1'b0;
    tbl_rd.idx     = pos_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req.op == OP_DECODE) begin
            data_nxt  = in_req.data_byte;
            rem_nxt   = REM_W'(DATA_W);
            state_nxt = ST_FETCH;
          end else if (in_req.op == OP_RESTART) begin
            started_nxt = 1'b0;
          end
        end
      end
      ST_FETCH: begin
        // A new walk starts at the root; otherwise re-read the node the walk is on.
        tbl_rd.en      = 1'b1;
        tbl_rd.idx     = started_r ? pos_r : root_r;
        pos_nxt        = tbl_rd.idx;
        started_nxt    = 1'b1;
        from_child_nxt = 1'b0;
        state_nxt      = ST_WALK;
      end
      ST_WALK: begin
        if (!stall) begin
          if (emit) begin
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_sym_nxt   = hold_sym_r;
              out_last_nxt  = 1'b0;
            end
            hold_valid_nxt = 1'b1;
            hold_sym_nxt   = entry.right_or_symbol[SYM_W-1:0];
            started_nxt    = 1'b0;
            // A leaf seen before any step means the root is a leaf: it eats a bit.
            if (!from_child_r) begin
              data_nxt = data_r << 1;
            end
            rem_nxt   = rem_after;
            state_nxt = (rem_after == '0) ? ST_FINISH : ST_FETCH;
          end else if (!from_child_r || (rem_r != '0)) begin
            tbl_rd.en      = 1'b1;
            tbl_rd.idx     = child;
            pos_nxt        = child;
            data_nxt       = data_r << 1;
            rem_nxt        = rem_r - REM_W'(1);
            from_child_nxt = 1'b1;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!hold_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sym_nxt    = hold_sym_r;
          out_last_nxt   = 1'b1;
          hold_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      started_r    <= 1'b0;
      from_child_r <= 1'b0;
      root_r       <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      rem_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      started_r    <= started_nxt;
      from_child_r <= from_child_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      rem_r        <= rem_nxt;
      if (cfg_we) begin
        root_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    hold_sym_r <= hold_sym_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

>>> sim/hufd_checker.sv
// Checker for the Huffman tree bit decoder: predicts decoded symbols and compares results.
module hufd_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  hufd_in_if                         in_mon,
  hufd_out_if                        out_mon,
  input  logic                       cfg_we,
  input  logic [hufd_pkg::IDX_W-1:0] cfg_wdata,
  output int unsigned                fail_count,
  output int unsigned                syms_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import hufd_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_of_byte;
  } decoded_sym_t;

  node_entry_t      code_tree [NODE_COUNT];
  decoded_sym_t     pending_syms [$];
  decoded_sym_t     want;
  logic [IDX_W-1:0] root_idx;
  logic [IDX_W-1:0] walk_pos;
  logic             walk_live;
  int unsigned      mismatch_total;

  function automatic node_entry_t fetch_node(input logic [IDX_W-1:0] idx);
    if (idx < NODE_COUNT) begin
      return code_tree[idx];
    end
    return '0;
  endfunction

  // Walks one coded byte MSB first and queues every symbol it completes.
  function automatic void walk_byte(input logic [DATA_W-1:0] coded);
    node_entry_t  cur;
    node_entry_t  hit;
    decoded_sym_t tail;
    int           b;
    int           first_new;
    first_new = pending_syms.size();
    for (b = DATA_W - 1; b >= 0; b--) begin
      if (!walk_live) begin
        walk_pos = root_idx;
        walk_live = 1'b1;
      end
      cur = fetch_node(walk_pos);
      if (cur.leaf) begin
        // The root itself is a leaf: every bit yields its symbol.
        hit = cur;
      end else begin
        walk_pos = coded[b] ? cur.right_or_symbol : cur.left_child;
        hit = fetch_node(walk_pos);
      end
      if (hit.leaf) begin
        pending_syms.push_back('{symbol: hit.right_or_symbol[SYM_W-1:0], last_of_byte: 1'b0});
        walk_live = 1'b0;
      end
    end
    if (pending_syms.size() > first_new) begin
      tail = pending_syms.pop_back();
      tail.last_of_byte = 1'b1;
      pending_syms.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_syms.delete();
      root_idx = '0;
      walk_pos = '0;
      walk_live = 1'b0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_syms.size() == 0) begin
          $error("symbol %0h arrived with no symbol pending", out_mon.symbol);
          mismatch_total++;
        end else begin
          want = pending_syms.pop_front();
          if (out_mon.symbol !== want.symbol) begin
            $error("symbol mismatch: expected %0h, got %0h", want.symbol, out_mon.symbol);
            mismatch_total++;
          end
          if (out_mon.last_of_byte !== want.last_of_byte) begin
            $error("last_of_byte mismatch: expected %0b, got %0b",
                   want.last_of_byte, out_mon.last_of_byte);
            mismatch_total++;
          end
        end
      end
      if (cfg_we) begin
        root_idx = cfg_wdata;
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.op)
          OP_WRITE: begin
            if (in_mon.node_index < NODE_COUNT) begin
              code_tree[in_mon.node_index] = '{leaf: in_mon.node_is_leaf,
                                               left_child: in_mon.left_child,
                                               right_or_symbol: in_mon.right_or_symbol};
            end
          end
          OP_DECODE: begin
            walk_byte(in_mon.data_byte);
          end
          OP_RESTART: begin
            walk_live = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
    fail_count <= mismatch_total;
    syms_due <= pending_syms.size();
  end

endmodule

>>> sim/tb.sv
// Testbench top of the Huffman tree bit decoder: clock, reset, request and result traffic, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hufd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int ROUNDS        = 3;
  localparam int TREES_PER_ROUND = 3;
  localparam int STREAM_LEN    = 18;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_wdata;
  int unsigned      chk_fails;
  int unsigned      syms_due;

  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  bit               hold_off_req;

  bit               node_written [NODE_COUNT];
  bit               node_taken [NODE_COUNT];
  logic [IDX_W-1:0] written_idx [$];

  hufd_in_if  in_ch ();
  hufd_out_if out_ch ();

  huffman_tree_bit_decoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  hufd_checker i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (chk_fails),
    .syms_due   (syms_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  task automatic offer(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] coded,
                       input logic [IDX_W-1:0] idx, input logic leaf,
                       input logic [IDX_W-1:0] left, input logic [IDX_W-1:0] right);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.op              <= op;
    in_ch.data_byte       <= coded;
    in_ch.node_index      <= idx;
    in_ch.node_is_leaf    <= leaf;
    in_ch.left_child      <= left;
    in_ch.right_or_symbol <= right;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_node(input logic [IDX_W-1:0] idx, input logic leaf,
                            input logic [IDX_W-1:0] left, input logic [IDX_W-1:0] right);
    offer(OP_WRITE, DATA_W'($urandom), idx, leaf, left, right);
    if (!node_written[idx]) begin
      node_written[idx] = 1'b1;
      written_idx.push_back(idx);
    end
  endtask

  task automatic decode(input logic [DATA_W-1:0] coded);
    offer(OP_DECODE, coded, IDX_W'($urandom), 1'($urandom), IDX_W'($urandom),
          IDX_W'($urandom));
  endtask

  task automatic send_control(input logic [OP_W-1:0] op);
    offer(op, DATA_W'($urandom), IDX_W'($urandom), 1'($urandom), IDX_W'($urandom),
          IDX_W'($urandom));
  endtask

  // Stops requests until every predicted symbol is out and the walk has finished.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (syms_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_root(input logic [IDX_W-1:0] root);
    cfg_we    <= 1'b1;
    cfg_wdata <= root;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] fresh_node();
    logic [IDX_W-1:0] idx;
    do begin
      idx = IDX_W'($urandom_range(0, NODE_COUNT - 1));
    end while (node_taken[idx]);
    node_taken[idx] = 1'b1;
    return idx;
  endfunction

  // Children are always written before their parent, so every written inner node
  // points at written nodes and no walk can reach an unwritten entry.
  task automatic build_tree(input int leaves, input bit chain, output logic [IDX_W-1:0] root);
    logic [IDX_W-1:0] forest [$];
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] idx;
    int               pick;
    int               i;
    for (i = 0; i < NODE_COUNT; i++) node_taken[i] = 1'b0;
    for (i = 0; i < leaves; i++) begin
      idx = fresh_node();
      write_node(idx, 1'b1, IDX_W'($urandom), IDX_W'($urandom));
      forest.push_back(idx);
    end
    while (forest.size() > 1) begin
      if (chain) begin
        a = forest.pop_back();
      end else begin
        pick = $urandom_range(0, forest.size() - 1);
        a = forest[pick];
        forest.delete(pick);
      end
      pick = $urandom_range(0, forest.size() - 1);
      b = forest[pick];
      forest.delete(pick);
      idx = fresh_node();
      if ($urandom_range(0, 1)) begin
        write_node(idx, 1'b0, a, b);
      end else begin
        write_node(idx, 1'b0, b, a);
      end
      forest.push_back(idx);
    end
    root = forest[0];
  endtask

  task automatic rewrite_random_node();
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    idx  = written_idx[$urandom_range(0, written_idx.size() - 1)];
    leaf = 1'($urandom_range(0, 1));
    left = written_idx[$urandom_range(0, written_idx.size() - 1)];
    if (leaf) begin
      right = IDX_W'($urandom);
    end else begin
      right = written_idx[$urandom_range(0, written_idx.size() - 1)];
    end
    write_node(idx, leaf, left, right);
  endtask

  initial begin
    logic [IDX_W-1:0] root;
    int               leaves;
    int               pick;
    int               rnd;
    int               t;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.op              <= OP_WRITE;
    in_ch.data_byte       <= '0;
    in_ch.node_index      <= '0;
    in_ch.node_is_leaf    <= 1'b0;
    in_ch.left_child      <= '0;
    in_ch.right_or_symbol <= '0;
    send_idle_pct = 31;
    recv_idle_pct = 73;
    hold_off_req  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a one-bit tree at the reset root, with symbol zero and a wide symbol.
    write_root('0);
    write_node(9'd511, 1'b1, 9'h1FF, 9'h1FF);
    write_node(9'd1, 1'b1, 9'h000, 9'h000);
    write_node(9'd0, 1'b0, 9'd1, 9'd511);
    decode(8'h00);
    decode(8'hFF);
    decode(8'hA5);
    offer(OP_UNUSED, 8'hFF, 9'h1FF, 1'b1, 9'h1FF, 9'h1FF);
    send_control(OP_RESTART);

    // Codes of one and two bits: some end on a byte boundary, some span two bytes.
    write_node(9'd22, 1'b1, IDX_W'($urandom), 9'h080);
    write_node(9'd21, 1'b0, 9'd22, 9'd511);
    write_node(9'd20, 1'b0, 9'd1, 9'd21);
    settle();
    write_root(9'd20);
    decode(8'hFF);
    decode(8'h80);
    decode(8'h01);
    decode(8'h7F);
    decode(8'h01);
    send_control(OP_RESTART);
    decode(8'h00);

    // The root is a leaf: every bit yields a symbol.
    settle();
    write_root(9'd511);
    decode(8'h3C);
    decode(8'hC3);

    for (int r = 0; r < ROUNDS; r++) begin
      settle();
      case (r)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (t = 0; t < TREES_PER_ROUND; t++) begin
        pick = $urandom_range(0, 9);
        leaves = (pick == 0) ? 1 : $urandom_range(2, 12);
        build_tree(leaves, $urandom_range(0, 3) == 0, root);
        settle();
        write_root(root);
        if (r == ROUNDS - 1 && t == 0) begin
          hold_off_req = 1'b1;
        end
        repeat (STREAM_LEN) begin
          rnd = $urandom_range(0, 99);
          if (rnd < 76) begin
            decode(DATA_W'($urandom));
          end else if (rnd < 84) begin
            send_control(OP_RESTART);
          end else if (rnd < 89) begin
            send_control(OP_UNUSED);
          end else begin
            rewrite_random_node();
          end
        end
      end
    end

    settle();
    if (chk_fails == 0 && syms_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> huffman_tree_bit_decoder_core.f
design/hufd_pkg.sv
design/hufd_in_if.sv
design/hufd_out_if.sv
design/hufd_node_table.sv
design/huffman_tree_bit_decoder_core.sv
sim/hufd_checker.sv
sim/tb.sv
